/* hdl/binomial_mod_prime_defines.svh */
// Assertion macros shared by the binomial coefficient block.
`ifndef BINOMIAL_MOD_PRIME_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define BMP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/bmp_pkg.sv */
// Package with the constants and types of the binomial coefficient block.
`timescale 1ns / 1ps
`default_nettype none
package bmp_pkg;

   localparam int RES_W = 30;
   localparam int CNT_W = 16;
   localparam int EXP_BITS = 30;

   localparam logic [RES_W-1:0] MOD_P = 30'd1000000007;
   localparam logic [RES_W-1:0] FERMAT_EXP = 30'd1000000005;
   localparam logic [31:0] MOD_2P = 32'd2000000014;
   localparam logic [30:0] BARRETT_MU = 31'd1152921496;

   typedef struct packed {
      logic             start;
      logic [RES_W-1:0] a;
      logic [RES_W-1:0] b;
   } mm_req_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] product;
   } mm_rsp_type;

endpackage
`default_nettype wire

/* hdl/bmp_mulmod.sv */
// Multicycle modular multiplier with Barrett reduction on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module bmp_mulmod (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bmp_pkg::mm_req_type mm_req,
   output bmp_pkg::mm_rsp_type      mm_rsp
);

   localparam logic [2:0] U_IDLE = 3'd0;
   localparam logic [2:0] U_M1   = 3'd1;
   localparam logic [2:0] U_M2   = 3'd2;
   localparam logic [2:0] U_M3   = 3'd3;
   localparam logic [2:0] U_COR  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [29:0] a_ff, a_in;
   logic [29:0] b_ff, b_in;
   logic [59:0] prod_ff, prod_in;
   logic [30:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic        done_ff, done_in;
   logic [29:0] res_ff, res_in;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;
   logic [31:0] r_m1;
   logic [31:0] r_m2;

   always_comb begin
      case (state_ff)
         U_M1: begin
            mul_a = {2'b00, a_ff};
            mul_b = {2'b00, b_ff};
         end
         U_M2: begin
            mul_a = {1'b0, prod_ff[59:29]};
            mul_b = {1'b0, bmp_pkg::BARRETT_MU};
         end
         U_M3: begin
            mul_a = {1'b0, q_ff};
            mul_b = {2'b00, bmp_pkg::MOD_P};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);
   assign r_m1 = r_ff - {2'b00, bmp_pkg::MOD_P};
   assign r_m2 = r_ff - bmp_pkg::MOD_2P;

   always_comb begin
      state_in = state_ff;
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      q_in = q_ff;
      r_in = r_ff;
      res_in = res_ff;
      done_in = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (mm_req.start) begin
               a_in = mm_req.a;
               b_in = mm_req.b;
               state_in = U_M1;
            end
         end
         U_M1: begin
            prod_in = mul_p[59:0];
            state_in = U_M2;
         end
         U_M2: begin
            q_in = mul_p[61:31];
            state_in = U_M3;
         end
         U_M3: begin
            r_in = prod_ff[31:0] - mul_p[31:0];
            state_in = U_COR;
         end
         U_COR: begin
            if (r_ff >= bmp_pkg::MOD_2P) begin
               res_in = r_m2[29:0];
            end else if (r_ff >= {2'b00, bmp_pkg::MOD_P}) begin
               res_in = r_m1[29:0];
            end else begin
               res_in = r_ff[29:0];
            end
            done_in = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      q_ff <= q_in;
      r_ff <= r_in;
      res_ff <= res_in;
   end

   assign mm_rsp.done = done_ff;
   assign mm_rsp.product = res_ff;

endmodule
`default_nettype wire

/* hdl/binomial_mod_prime.sv */
// Top level of the binomial coefficient modulo 1000000007 block.
// Usage:
//   An input word on the req_ channel carries n (req_top_value) and k
//   (req_choose_count). One result word on the rsp_ channel carries C(n,k) mod
//   1000000007. Both channels use valid and ready.
//   The block works on one word at a time and holds req_ready low until the
//   result has been loaded into the output register.
//   Every modular product runs on one shared multiplier in bmp_mulmod, one
//   product at a time. The loop spends two products per unit of k, the
//   inverse of k! takes 44 more and the final product one; after them the
//   word is loaded into the output register. A word with k above n mod
//   1000000007 or above MAX_CHOOSE starts no product and goes from idle
//   straight to the done state, where a zero result is loaded into the
//   output register.
//   If the receiver stalls, the finished result waits in the output register
//   and the block can take the next input word; that word's result waits
//   until the previous one is taken.
//   Synchronous reset returns the sequencer to idle and empties the output
//   register.
`timescale 1ns / 1ps
`default_nettype none
`include "binomial_mod_prime_defines.svh"
module binomial_mod_prime #(
   parameter int MAX_CHOOSE = 65535
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [29:0] req_top_value,
   input  wire logic [15:0] req_choose_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [29:0]      rsp_coefficient
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FALL  = 3'd1;
   localparam logic [2:0] S_FACT  = 3'd2;
   localparam logic [2:0] S_PMUL  = 3'd3;
   localparam logic [2:0] S_PSQR  = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;
   localparam logic [4:0] LAST_BIT = 5'(bmp_pkg::EXP_BITS - 1);

   logic [2:0]  state_ff, state_in;
   logic        pending_ff, pending_in;
   logic [29:0] n_ff, n_in;
   logic [15:0] k_ff, k_in;
   logic [15:0] j_ff, j_in;
   logic [29:0] fall_ff, fall_in;
   logic [29:0] fact_ff, fact_in;
   logic [29:0] acc_ff, acc_in;
   logic [29:0] base_ff, base_in;
   logic [4:0]  bit_ff, bit_in;
   logic [29:0] result_ff, result_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [29:0] rsp_coefficient_ff, rsp_coefficient_in;
   logic [29:0] n_red;
   logic        accept;
   logic [16:0] j_next;
   bmp_pkg::mm_req_type mm_req;
   bmp_pkg::mm_rsp_type mm_rsp;

   bmp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign n_red = (req_top_value >= bmp_pkg::MOD_P) ? req_top_value - bmp_pkg::MOD_P
                                                   : req_top_value;
   assign j_next = {1'b0, j_ff} + 17'd1;

   always_comb begin
      mm_req.start = 1'b0;
      mm_req.a = fall_ff;
      mm_req.b = 30'd0;
      case (state_ff)
         S_FALL: begin
            mm_req.start = !pending_ff && (j_ff != k_ff);
            mm_req.a = fall_ff;
            mm_req.b = n_ff - {14'd0, j_ff};
         end
         S_FACT: begin
            mm_req.start = !pending_ff;
            mm_req.a = fact_ff;
            mm_req.b = {13'd0, j_next};
         end
         S_PMUL: begin
            mm_req.start = !pending_ff && bmp_pkg::FERMAT_EXP[bit_ff];
            mm_req.a = acc_ff;
            mm_req.b = base_ff;
         end
         S_PSQR: begin
            mm_req.start = !pending_ff && (bit_ff != LAST_BIT);
            mm_req.a = base_ff;
            mm_req.b = base_ff;
         end
         S_FINAL: begin
            mm_req.start = !pending_ff;
            mm_req.a = fall_ff;
            mm_req.b = acc_ff;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pending_in = pending_ff;
      n_in = n_ff;
      k_in = k_ff;
      j_in = j_ff;
      fall_in = fall_ff;
      fact_in = fact_ff;
      acc_in = acc_ff;
      base_in = base_ff;
      bit_in = bit_ff;
      result_in = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_coefficient_in = rsp_coefficient_ff;
      if (mm_req.start) begin
         pending_in = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in = n_red;
               k_in = req_choose_count;
               j_in = 16'd0;
               fall_in = 30'd1;
               fact_in = 30'd1;
               if ((32'(req_choose_count) > MAX_CHOOSE) || ({14'd0, req_choose_count} > n_red))
               begin
                  result_in = 30'd0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FALL;
               end
            end
         end
         S_FALL: begin
            if (j_ff == k_ff) begin
               acc_in = 30'd1;
               base_in = fact_ff;
               bit_in = 5'd0;
               state_in = S_PMUL;
            end else if (mm_rsp.done) begin
               pending_in = 1'b0;
               fall_in = mm_rsp.product;
               state_in = S_FACT;
            end
         end
         S_FACT: begin
            if (mm_rsp.done) begin
               pending_in = 1'b0;
               fact_in = mm_rsp.product;
               j_in = j_next[15:0];
               state_in = S_FALL;
            end
         end
         S_PMUL: begin
            if (!bmp_pkg::FERMAT_EXP[bit_ff]) begin
               state_in = S_PSQR;
            end else if (mm_rsp.done) begin
               pending_in = 1'b0;
               acc_in = mm_rsp.product;
               state_in = S_PSQR;
            end
         end
         S_PSQR: begin
            if (bit_ff == LAST_BIT) begin
               state_in = S_FINAL;
            end else if (mm_rsp.done) begin
               pending_in = 1'b0;
               base_in = mm_rsp.product;
               bit_in = bit_ff + 5'd1;
               state_in = S_PMUL;
            end
         end
         S_FINAL: begin
            if (mm_rsp.done) begin
               pending_in = 1'b0;
               result_in = mm_rsp.product;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_coefficient_in = result_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      k_ff <= k_in;
      j_ff <= j_in;
      fall_ff <= fall_in;
      fact_ff <= fact_in;
      acc_ff <= acc_in;
      base_ff <= base_in;
      bit_ff <= bit_in;
      result_ff <= result_in;
      rsp_coefficient_ff <= rsp_coefficient_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;

   `BMP_ASSERT_IMP(a_rsp_reduced, rsp_valid, rsp_coefficient < bmp_pkg::MOD_P, "result not reduced")
   `BMP_ASSERT_IMP(a_done_pending, mm_rsp.done, pending_ff, "product arrived unrequested")
   `BMP_ASSERT_NXT(a_busy_after_accept, accept, !req_ready, "ready after accepting a word")

endmodule
`default_nettype wire

/* sim/bmp_checker.sv */
// Checker that predicts and compares the coefficient words of binomial_mod_prime.
`timescale 1ns / 1ps
module bmp_checker #(
   parameter int MAX_CHOOSE = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [29:0] req_top_value,
   input  logic [15:0] req_choose_count,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [29:0] rsp_coefficient,
   input  logic        end_of_test,
   output int          outstanding,
   output int          fail_count
);

   typedef struct {
      logic [29:0] top_value;
      logic [15:0] choose_count;
      logic [29:0] coefficient;
   } binom_case_type;

   binom_case_type coeff_due[$];
   int due_count = 0;
   int mismatches = 0;
   logic end_seen = 1'b0;

   assign outstanding = due_count;
   assign fail_count = mismatches;

   function automatic logic [63:0] mul_mod_p(input logic [63:0] a, input logic [63:0] b);
      return (a * b) % {34'd0, bmp_pkg::MOD_P};
   endfunction

   function automatic logic [63:0] pow_mod_p(input logic [63:0] base,
                                             input logic [29:0] exponent);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1;
      sq = base % {34'd0, bmp_pkg::MOD_P};
      for (int bit_idx = 0; bit_idx < 30; bit_idx++) begin
         if (exponent[bit_idx]) acc = mul_mod_p(acc, sq);
         sq = mul_mod_p(sq, sq);
      end
      return acc;
   endfunction

   // The falling product is divided by k! through its Fermat inverse.
   function automatic logic [29:0] binom_mod_p(input logic [29:0] top_value,
                                               input logic [15:0] choose_count);
      logic [63:0] n;
      logic [63:0] falling;
      logic [63:0] fact;
      n = {34'd0, top_value} % {34'd0, bmp_pkg::MOD_P};
      if (int'(choose_count) > MAX_CHOOSE || {48'd0, choose_count} > n) return '0;
      falling = 64'd1;
      fact = 64'd1;
      for (int j = 0; j < int'(choose_count); j++) begin
         falling = mul_mod_p(falling, n - 64'(j));
         fact = mul_mod_p(fact, 64'(j + 1));
      end
      return 30'(mul_mod_p(falling, pow_mod_p(fact, bmp_pkg::FERMAT_EXP)));
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      binom_case_type head;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (coeff_due.size() == 0) begin
               report_mismatch($sformatf("result word %0d arrived with none expected",
                                         rsp_coefficient));
            end else begin
               head = coeff_due.pop_front();
               if (rsp_coefficient !== head.coefficient) begin
                  report_mismatch($sformatf("n=%0d k=%0d: coefficient %0d, expected %0d",
                                            head.top_value, head.choose_count,
                                            rsp_coefficient, head.coefficient));
               end
            end
         end
         if (req_valid && req_ready) begin
            coeff_due.push_back('{req_top_value, req_choose_count,
                                  binom_mod_p(req_top_value, req_choose_count)});
         end
         if (end_of_test && !end_seen) begin
            end_seen = 1'b1;
            if (coeff_due.size() != 0) begin
               report_mismatch($sformatf("%0d result words never arrived", coeff_due.size()));
            end
         end
         due_count <= coeff_due.size();
      end
   end

endmodule

/* sim/tb_binomial_mod_prime.sv */
// Testbench top that drives binomial_mod_prime and gives the verdict.
`timescale 1ns / 1ps
module tb_binomial_mod_prime;

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int WORDS_PER_PHASE = 25;
   localparam int PHASES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [29:0] req_top_value = '0;
   logic [15:0] req_choose_count = '0;
   logic rsp_ready = 1'b1;
   logic end_of_test = 1'b0;
   wire req_ready;
   wire rsp_valid;
   wire [29:0] rsp_coefficient;
   int outstanding;
   int fail_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int idle_plan[PHASES] = '{0, 54, 0, 25};
   int stall_plan[PHASES] = '{0, 0, 54, 25};

   binomial_mod_prime #(.MAX_CHOOSE(65535)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_top_value(req_top_value),
      .req_choose_count(req_choose_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_coefficient(rsp_coefficient)
   );

   bmp_checker #(.MAX_CHOOSE(65535)) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_top_value(req_top_value),
      .req_choose_count(req_choose_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_coefficient(rsp_coefficient),
      .end_of_test(end_of_test),
      .outstanding(outstanding),
      .fail_count(fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Called and returning at a falling edge.
   task automatic send_word(input logic [29:0] n, input logic [15:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_top_value <= n;
      req_choose_count <= k;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Mostly small counts; some counts above n, some close to n, values around the modulus,
   // and a few medium counts.
   task automatic send_random_word();
      int pick;
      int k;
      int n;
      pick = $urandom_range(99);
      if (pick < 55) begin
         k = $urandom_range(40);
         n = $urandom_range(30'h3FFFFFFF);
      end else if (pick < 70) begin
         k = $urandom_range(65535, 1);
         n = $urandom_range(k - 1);
      end else if (pick < 80) begin
         k = $urandom_range(30, 1);
         n = k - 1 + $urandom_range(2);
      end else if (pick < 92) begin
         k = $urandom_range(12);
         n = bmp_pkg::MOD_P - 3 + $urandom_range(6);
      end else begin
         k = $urandom_range(600, 100);
         n = $urandom_range(30'h3FFFFFFF);
      end
      send_word(n[29:0], k[15:0]);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(30'd0, 16'd0);
      send_word(30'd0, 16'd1);
      send_word(30'd5, 16'd0);
      send_word(30'd5, 16'd5);
      send_word(30'd5, 16'd6);
      send_word(30'd10, 16'd3);
      send_word(30'd52, 16'd5);
      send_word(bmp_pkg::MOD_P - 30'd1, 16'd1);
      send_word(bmp_pkg::MOD_P - 30'd1, 16'd2);
      send_word(bmp_pkg::MOD_P, 16'd0);
      send_word(bmp_pkg::MOD_P, 16'd1);
      send_word(bmp_pkg::MOD_P + 30'd3, 16'd2);
      send_word(30'h3FFFFFFF, 16'd0);
      send_word(30'h3FFFFFFF, 16'd7);
      send_word(30'd100, 16'hFFFF);
      send_word(bmp_pkg::MOD_P + 30'd5, 16'hFFFF);
      send_word(30'd1, 16'h8000);
      send_word(30'd12345, 16'h5555);
      send_word(30'd1000, 16'd999);
      send_word(bmp_pkg::MOD_P - 30'd1, 16'hFFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         send_idle_pct = idle_plan[phase];
         stall_pct = stall_plan[phase];
         for (int i = 0; i < WORDS_PER_PHASE; i++) send_random_word();
         req_valid <= 1'b0;
         do @(negedge clock); while (outstanding != 0);
      end

      repeat (30) @(negedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
